FILE: hdl/efha_pkg.sv
// Package for the exact-fit heap allocator.
// Field widths, response codes, controller states and the command/status
// structs shared by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package efha_pkg;

   localparam int SIZE_W       = 14;
   localparam int ADDR_W       = 12;
   localparam int STATUS_W     = 2;
   localparam int LIMIT_W      = 13;
   localparam int WORD_W       = 32;
   localparam int HEADER_WORDS = 2;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_PREP   = 8'b0000_0010,
      ST_WALK1  = 8'b0000_0100,
      ST_WALK2  = 8'b0000_1000,
      ST_CARVE  = 8'b0001_0000,
      ST_CARVE2 = 8'b0010_0000,
      ST_FREE1  = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic take_req;    // latch request fields
      logic walk_start;  // p = 0, read header word 0 of first block
      logic walk_hdr;    // capture word 0, read word 1
      logic walk_step;   // follow next link, read its word 0
      logic hit_write;   // clear free bit of matching block
      logic fail_space;  // out of arena space
      logic carve_hdr;   // write header word 0 at bump pointer
      logic carve_len;   // write length word, advance bump pointer
      logic bad_free;    // free address rejected
      logic free_rd;     // read header word of block being freed
      logic free_wr;     // set its free bit
      logic rsp_load;    // move result into output register
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_free;
      logic bump_zero;
      logic bad_addr;
      logic hit;
      logic chain_end;
      logic no_space;
   } dp_status_type;

endpackage

FILE: hdl/exact_fit_heap_allocator_top.sv
// Top level of the exact-fit heap allocator.
// Joins efha_ctrl and efha_datapath; uses efha_pkg.
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    req_command, req_size_bytes, req_block_address
//  rsp      out        rsp_valid/rsp_ready    rsp_payload_address, rsp_status
//  csr      in         csr_valid/csr_ready    csr_arena_limit
//
// Allocate walks the block chain, unless the bump pointer is zero, and returns an
// exact-fit hit, else carves a block at the bump pointer or reports out of space.
// The arena reads one header word per cycle. Free reads, then sets, a free bit.
// Reset is synchronous: bump pointer to zero, limit to 4096, arena left as is.
// One request is in flight at a time; the next is taken once the result sits
// in the output register, and a stalled result only holds the finished request.
`timescale 1ns / 1ps

module exact_fit_heap_allocator_top
   import efha_pkg::*;
#(
   parameter int ARENA_WORDS = 4096,
   parameter int WORD_BYTES  = 4
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [SIZE_W-1:0]   req_size_bytes,
   input  logic [ADDR_W-1:0]   req_block_address,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [ADDR_W-1:0]   rsp_payload_address,
   output logic [STATUS_W-1:0] rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LIMIT_W-1:0]  csr_arena_limit
);

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_stat;

   assign csr_ready = 1'b1;

   efha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_stat   (dp_stat),
      .ctl_cmd   (ctl_cmd)
   );

   efha_datapath #(
      .ARENA_WORDS (ARENA_WORDS),
      .WORD_BYTES  (WORD_BYTES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_command         (req_command),
      .req_size_bytes      (req_size_bytes),
      .req_block_address   (req_block_address),
      .csr_write           (csr_valid & csr_ready),
      .csr_arena_limit     (csr_arena_limit),
      .ctl_cmd             (ctl_cmd),
      .dp_stat             (dp_stat),
      .rsp_payload_address (rsp_payload_address),
      .rsp_status          (rsp_status)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl_cmd.hit_write, ctl_cmd.carve_hdr, ctl_cmd.carve_len, ctl_cmd.free_wr}))
      else $error("arena written from two sources");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.rsp_load |-> (!rsp_valid || rsp_ready))
      else $error("output register overwritten");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_payload_address == '0))
      else $error("failed request returned an address");

endmodule

FILE: hdl/efha_ctrl.sv
// Controller state machine of the exact-fit heap allocator.
// Sequences the header walk, carving and freeing; uses efha_pkg.
`timescale 1ns / 1ps

module efha_ctrl
   import efha_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_stat,
   output ctl_cmd_type   ctl_cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctl_cmd  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl_cmd.take_req = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (dp_stat.is_free) begin
               if (dp_stat.bad_addr) begin
                  ctl_cmd.bad_free = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  ctl_cmd.free_rd = 1'b1;
                  state_in = ST_FREE1;
               end
            end else if (dp_stat.bump_zero) begin
               state_in = ST_CARVE;
            end else begin
               ctl_cmd.walk_start = 1'b1;
               state_in = ST_WALK1;
            end
         end
         ST_WALK1: begin
            ctl_cmd.walk_hdr = 1'b1;
            state_in = ST_WALK2;
         end
         ST_WALK2: begin
            priority if (dp_stat.hit) begin
               ctl_cmd.hit_write = 1'b1;
               state_in = ST_DONE;
            end else if (dp_stat.chain_end) begin
               state_in = ST_CARVE;
            end else begin
               ctl_cmd.walk_step = 1'b1;
               state_in = ST_WALK1;
            end
         end
         ST_CARVE: begin
            if (dp_stat.no_space) begin
               ctl_cmd.fail_space = 1'b1;
               state_in = ST_DONE;
            end else begin
               ctl_cmd.carve_hdr = 1'b1;
               state_in = ST_CARVE2;
            end
         end
         ST_CARVE2: begin
            ctl_cmd.carve_len = 1'b1;
            state_in = ST_DONE;
         end
         ST_FREE1: begin
            ctl_cmd.free_wr = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl_cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (ctl_cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/efha_datapath.sv
// Datapath of the exact-fit heap allocator: arena memory, bump pointer,
// limit register, walk pointer and result registers; uses efha_pkg.
`timescale 1ns / 1ps

module efha_datapath
   import efha_pkg::*;
#(
   parameter int ARENA_WORDS = 4096,
   parameter int WORD_BYTES  = 4
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_command,
   input  logic [SIZE_W-1:0]   req_size_bytes,
   input  logic [ADDR_W-1:0]   req_block_address,
   input  logic                csr_write,
   input  logic [LIMIT_W-1:0]  csr_arena_limit,
   input  ctl_cmd_type         ctl_cmd,
   output dp_status_type       dp_stat,
   output logic [ADDR_W-1:0]   rsp_payload_address,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int AW       = $clog2(ARENA_WORDS);
   localparam int BP_W     = $clog2(ARENA_WORDS + 1);
   localparam int NUM_W    = $clog2(2**SIZE_W - 1 + WORD_BYTES);
   // reciprocal exact for numerators below 2**NUM_W and divisors up to 8
   localparam int SHIFT    = NUM_W + 3;
   localparam int RCP_W    = SHIFT + 1;
   localparam int RECIP    = (2**SHIFT + WORD_BYTES - 1) / WORD_BYTES;
   localparam int PROD_W   = NUM_W + RCP_W;
   localparam int NEED_MAX = (2**SIZE_W - 1 + WORD_BYTES - 1) / WORD_BYTES + HEADER_WORDS;
   localparam int NEED_W   = $clog2(NEED_MAX + 1);
   localparam int MAX_A    = (BP_W > NEED_W) ? BP_W : NEED_W;
   localparam int SUM_W    = ((MAX_A > LIMIT_W) ? MAX_A : LIMIT_W) + 1;
   localparam int CMP_W    = (ADDR_W > BP_W) ? ADDR_W : BP_W;
   localparam int PW       = SUM_W + ADDR_W;

   logic [WORD_W-1:0] arena_mem [ARENA_WORDS];
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_en, wr_en;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic [WORD_W-1:0] wr_data;

   logic                cmd_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [NEED_W-1:0]   need_ff;
   logic [BP_W-1:0]     bump_ff;
   logic [BP_W-1:0]     p_ff;
   logic [WORD_W-1:0]   w0_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [ADDR_W-1:0]   res_addr_ff;
   status_type          res_status_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   status_type          rsp_status_ff;

   logic [NUM_W-1:0]  num;
   logic [PROD_W-1:0] prod;
   logic [NEED_W-1:0] need_calc;
   logic [WORD_W-2:0] nx;
   logic [SUM_W-1:0]  carve_sum;
   logic [CMP_W-1:0]  h_full;
   logic [AW-1:0]     h_addr;

   function automatic logic [ADDR_W-1:0] to_port(input logic [SUM_W-1:0] v);
      logic [PW-1:0] t;
      t = PW'(v);
      return t[ADDR_W-1:0];
   endfunction

   // need = ceil(bytes / WORD_BYTES) + HEADER_WORDS, the division by reciprocal multiply
   assign num       = NUM_W'(size_ff) + NUM_W'(WORD_BYTES - 1);
   assign prod      = {{RCP_W{1'b0}}, num} * {{NUM_W{1'b0}}, RCP_W'(RECIP)};
   assign need_calc = NEED_W'(prod >> SHIFT) + NEED_W'(HEADER_WORDS);

   assign nx        = w0_ff[WORD_W-1:1];
   assign carve_sum = SUM_W'(bump_ff) + SUM_W'(need_ff);
   assign h_full    = CMP_W'(addr_ff) - CMP_W'(HEADER_WORDS);
   assign h_addr    = h_full[AW-1:0];

   always_comb begin
      dp_stat.is_free   = (cmd_ff == CMD_FREE);
      dp_stat.bump_zero = (bump_ff == '0);
      dp_stat.bad_addr  = (addr_ff == '0) || (CMP_W'(addr_ff) >= CMP_W'(bump_ff))
                          || (addr_ff < ADDR_W'(HEADER_WORDS));
      dp_stat.hit       = w0_ff[0] && (rd_data_ff == WORD_W'(need_ff));
      dp_stat.chain_end = (nx <= (WORD_W-1)'(p_ff)) || (nx >= (WORD_W-1)'(bump_ff));
      dp_stat.no_space  = (carve_sum > SUM_W'(limit_ff)) || (carve_sum > SUM_W'(ARENA_WORDS));
   end

   // arena port select
   always_comb begin
      rd_en   = ctl_cmd.walk_start | ctl_cmd.walk_hdr | ctl_cmd.walk_step | ctl_cmd.free_rd;
      rd_addr = '0;
      priority if (ctl_cmd.free_rd) begin
         rd_addr = h_addr;
      end else if (ctl_cmd.walk_hdr) begin
         rd_addr = p_ff[AW-1:0] + AW'(1);
      end else if (ctl_cmd.walk_step) begin
         rd_addr = nx[AW-1:0];
      end else begin
         rd_addr = '0;
      end

      wr_en   = ctl_cmd.hit_write | ctl_cmd.carve_hdr | ctl_cmd.carve_len | ctl_cmd.free_wr;
      wr_addr = '0;
      wr_data = '0;
      priority if (ctl_cmd.hit_write) begin
         wr_addr = p_ff[AW-1:0];
         wr_data = {w0_ff[WORD_W-1:1], 1'b0};
      end else if (ctl_cmd.carve_hdr) begin
         wr_addr = bump_ff[AW-1:0];
         wr_data = {(WORD_W-1)'(carve_sum), 1'b0};
      end else if (ctl_cmd.carve_len) begin
         wr_addr = bump_ff[AW-1:0] + AW'(1);
         wr_data = WORD_W'(need_ff);
      end else if (ctl_cmd.free_wr) begin
         wr_addr = h_addr;
         wr_data = {rd_data_ff[WORD_W-1:1], 1'b1};
      end else begin
         wr_data = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         arena_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= arena_mem[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl_cmd.take_req) begin
         cmd_ff  <= req_command;
         size_ff <= req_size_bytes;
         addr_ff <= req_block_address;
      end
      if (ctl_cmd.walk_start || ctl_cmd.free_rd || ctl_cmd.bad_free) begin
         need_ff <= need_calc;
      end else if (cmd_ff == CMD_ALLOC && dp_stat.bump_zero && ctl_cmd == '0) begin
         need_ff <= need_calc;
      end
      if (ctl_cmd.walk_start) begin
         p_ff <= '0;
      end else if (ctl_cmd.walk_step) begin
         p_ff <= BP_W'(nx);
      end
      if (ctl_cmd.walk_hdr) begin
         w0_ff <= rd_data_ff;
      end
      priority if (ctl_cmd.hit_write) begin
         res_addr_ff   <= to_port(SUM_W'(p_ff) + SUM_W'(HEADER_WORDS));
         res_status_ff <= STATUS_OK;
      end else if (ctl_cmd.carve_len) begin
         res_addr_ff   <= to_port(SUM_W'(bump_ff) + SUM_W'(HEADER_WORDS));
         res_status_ff <= STATUS_OK;
      end else if (ctl_cmd.fail_space) begin
         res_addr_ff   <= '0;
         res_status_ff <= STATUS_NO_SPACE;
      end else if (ctl_cmd.bad_free) begin
         res_addr_ff   <= '0;
         res_status_ff <= STATUS_BAD_FREE;
      end else if (ctl_cmd.free_wr) begin
         res_addr_ff   <= '0;
         res_status_ff <= STATUS_OK;
      end else begin
         res_addr_ff   <= res_addr_ff;
      end
      if (ctl_cmd.rsp_load) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bump_ff  <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         if (ctl_cmd.carve_len) begin
            bump_ff <= BP_W'(carve_sum);
         end
         if (csr_write) begin
            limit_ff <= csr_arena_limit;
         end
      end
   end

   assign rsp_payload_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

FILE: verif/exact_fit_heap_allocator_top_tb.sv
// Testbench for exact_fit_heap_allocator_top: directed and random alloc/free
// requests checked against an in-bench heap predictor. Depends on efha_pkg.
`timescale 1ns / 1ps

module exact_fit_heap_allocator_top_tb;
   import efha_pkg::*;

   localparam int ARENA_WORDS = 4096;
   localparam int WORD_BYTES  = 4;
   localparam int CYCLE_LIMIT = 40_000_000;

   typedef struct {
      logic [ADDR_W-1:0] payload;
      status_type        status;
   } alloc_result_type;

   // Heap predictor plus the queue of results it has worked out.
   class heap_scoreboard;
      bit [WORD_W-1:0]  heap [ARENA_WORDS];
      bit               written [ARENA_WORDS];
      int unsigned      bump_ptr;
      int unsigned      arena_limit;
      alloc_result_type result_q[$];
      int unsigned      block_starts[$];
      int unsigned      free_lens[$];
      int unsigned      live_payloads[$];
      int               errors;
      int               checked;
      int               reuse_count;
      int               status_count[3];

      function new();
         bump_ptr    = 0;
         arena_limit = 32'(LIMIT_RESET);
         errors      = 0;
         checked     = 0;
         reuse_count = 0;
         foreach (status_count[i]) status_count[i] = 0;
      endfunction

      function bit [WORD_W-1:0] read_word(int unsigned i);
         return (i < ARENA_WORDS) ? heap[i] : '0;
      endfunction

      function void write_word(int unsigned i, bit [WORD_W-1:0] v);
         if (i < ARENA_WORDS) begin
            heap[i]    = v;
            written[i] = 1'b1;
         end
      endfunction

      // A free inside the arena touches the word two below; it must be a header word.
      function bit free_is_legal(int unsigned addr);
         return addr < HEADER_WORDS || addr >= bump_ptr || written[addr - HEADER_WORDS];
      endfunction

      // Walk the block chain and collect starts, free lengths and live payloads.
      function void scan();
         int unsigned p;
         bit [WORD_W-1:0] w0;
         block_starts.delete();
         free_lens.delete();
         live_payloads.delete();
         p = 0;
         while (p < bump_ptr) begin
            w0 = read_word(p);
            block_starts.push_back(p);
            if (w0[0]) free_lens.push_back(read_word(p + 1));
            else live_payloads.push_back(p + HEADER_WORDS);
            if ((w0 >> 1) <= p) break;
            p = w0 >> 1;
         end
      endfunction

      function void note_request(command_type cmd, logic [SIZE_W-1:0] size,
                                 logic [ADDR_W-1:0] addr);
         int unsigned need, p, nx, eff, b;
         bit [WORD_W-1:0] w0;
         bit found;
         alloc_result_type res;
         res.payload = '0;
         res.status  = STATUS_OK;
         if (cmd == CMD_ALLOC) begin
            need  = (int'(size) + WORD_BYTES - 1) / WORD_BYTES + HEADER_WORDS;
            p     = 0;
            found = 1'b0;
            while (p < bump_ptr) begin
               w0 = read_word(p);
               nx = w0 >> 1;
               if (w0[0] && read_word(p + 1) == need) begin
                  write_word(p, w0 & ~32'd1);
                  res.payload = ADDR_W'(p + HEADER_WORDS);
                  found = 1'b1;
                  reuse_count++;
                  break;
               end
               // broken chain: link does not move forward
               if (nx <= p) break;
               p = nx;
            end
            if (!found) begin
               eff = (arena_limit > ARENA_WORDS) ? ARENA_WORDS : arena_limit;
               if (bump_ptr + need > eff) begin
                  res.status = STATUS_NO_SPACE;
               end else begin
                  b        = bump_ptr;
                  bump_ptr = b + need;
                  write_word(b, bump_ptr << 1);
                  write_word(b + 1, need);
                  res.payload = ADDR_W'(b + HEADER_WORDS);
               end
            end
         end else begin
            if (addr == 0 || addr >= bump_ptr || addr < HEADER_WORDS) begin
               res.status = STATUS_BAD_FREE;
            end else begin
               write_word(addr - HEADER_WORDS, read_word(addr - HEADER_WORDS) | 32'd1);
            end
         end
         result_q.push_back(res);
      endfunction

      function void check_result(logic [ADDR_W-1:0] payload, logic [STATUS_W-1:0] status);
         alloc_result_type exp;
         if (result_q.size() == 0) begin
            $error("response with no request pending: payload_address %0d status %0d",
                   payload, status);
            errors++;
            return;
         end
         exp = result_q.pop_front();
         checked++;
         status_count[exp.status]++;
         if (payload !== exp.payload) begin
            $error("payload_address expected %0d actual %0d", exp.payload, payload);
            errors++;
         end
         if (status !== exp.status) begin
            $error("status expected %0d actual %0d", exp.status, status);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_command;
   logic [SIZE_W-1:0]   req_size_bytes;
   logic [ADDR_W-1:0]   req_block_address;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [ADDR_W-1:0]   rsp_payload_address;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_valid;
   logic                csr_ready;
   logic [LIMIT_W-1:0]  csr_arena_limit;

   heap_scoreboard heap_model;
   bit             idle_enable;
   int             sent_count;
   int unsigned    last_limit;

   exact_fit_heap_allocator_top #(
      .ARENA_WORDS(ARENA_WORDS),
      .WORD_BYTES (WORD_BYTES)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_size_bytes     (req_size_bytes),
      .req_block_address  (req_block_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_address(rsp_payload_address),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_arena_limit    (csr_arena_limit)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // response side: ready drops in random bursts while idle_enable is set
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(0, 5);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         heap_model.check_result(rsp_payload_address, rsp_status);
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[exact_fit_heap_allocator_top] ERROR");
      $finish;
   end

   task automatic send_request(command_type cmd, logic [SIZE_W-1:0] size,
                               logic [ADDR_W-1:0] addr);
      // a free whose header word was never written is out of contract
      if (cmd == CMD_FREE && !heap_model.free_is_legal(32'(addr)))
         addr = ADDR_W'(heap_model.bump_ptr);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_size_bytes    <= size;
      req_block_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      heap_model.note_request(cmd, size, addr);
      sent_count++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (heap_model.result_q.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_arena_limit(logic [LIMIT_W-1:0] value);
      wait_idle();
      csr_valid       <= 1'b1;
      csr_arena_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      heap_model.arena_limit = 32'(value);
      last_limit = 32'(value);
   endtask

   // Mostly well-formed traffic: allocs that often match a freed block exactly,
   // frees of live blocks, plus header-word frees and bad addresses.
   task automatic random_requests(int count);
      int unsigned roll, sub, len, b;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
      for (int i = 0; i < count; i++) begin
         heap_model.scan();
         roll = $urandom_range(0, 99);
         size = SIZE_W'($urandom_range(0, 16383));
         addr = ADDR_W'($urandom_range(0, 4095));
         if (roll < 45) begin
            sub = $urandom_range(0, 19);
            if (sub < 8 && heap_model.free_lens.size() > 0) begin
               len = heap_model.free_lens[$urandom_range(0, heap_model.free_lens.size() - 1)];
               size = (len <= HEADER_WORDS) ? '0 :
                      SIZE_W'($urandom_range((len - 3) * WORD_BYTES + 1,
                                             (len - 2) * WORD_BYTES));
            end else if (sub == 8) begin
               size = '0;
            end else if (sub != 9) begin
               size = SIZE_W'($urandom_range(0, 255));
            end
            send_request(CMD_ALLOC, size, addr);
         end else if (roll < 85) begin
            if (heap_model.live_payloads.size() > 0)
               addr = ADDR_W'(heap_model.live_payloads[
                         $urandom_range(0, heap_model.live_payloads.size() - 1)]);
            send_request(CMD_FREE, size, addr);
         end else if (roll < 92) begin
            // double free, or a free that lands on a length word
            if (heap_model.block_starts.size() > 0) begin
               b = heap_model.block_starts[
                      $urandom_range(0, heap_model.block_starts.size() - 1)];
               addr = ADDR_W'(b + HEADER_WORDS + $urandom_range(0, 1));
            end
            send_request(CMD_FREE, size, addr);
         end else begin
            sub = $urandom_range(0, 3);
            if (sub == 0) addr = '0;
            else if (sub == 1) addr = ADDR_W'(1);
            else if (sub == 2 && heap_model.bump_ptr < ARENA_WORDS)
               addr = ADDR_W'($urandom_range(heap_model.bump_ptr, ARENA_WORDS - 1));
            send_request(CMD_FREE, size, addr);
         end
      end
   endtask

   initial begin
      heap_model  = new();
      idle_enable = 1'b1;
      sent_count  = 0;
      last_limit  = 32'(LIMIT_RESET);
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_command       <= CMD_ALLOC;
      req_size_bytes    <= '0;
      req_block_address <= '0;
      csr_valid         <= 1'b0;
      csr_arena_limit   <= LIMIT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset limit
      send_request(CMD_FREE,  14'd0,     12'd0);      // bad: arena base
      send_request(CMD_FREE,  14'd16383, 12'd4095);   // bad: past bump pointer
      send_request(CMD_ALLOC, 14'd0,     12'd4095);   // header-only block
      send_request(CMD_ALLOC, 14'd1,     12'd0);
      send_request(CMD_ALLOC, 14'd4,     12'd0);
      send_request(CMD_ALLOC, 14'd5,     12'd0);
      send_request(CMD_FREE,  14'd0,     12'd1);      // bad: below header size
      send_request(CMD_FREE,  14'd0,     12'd2);
      send_request(CMD_ALLOC, 14'd0,     12'd0);      // exact-fit reuse of first block
      send_request(CMD_FREE,  14'd0,     12'd7);
      send_request(CMD_ALLOC, 14'd3,     12'd0);      // reuse after walking two blocks
      send_request(CMD_FREE,  14'd0,     12'd3);      // sets bit 0 of a length word
      send_request(CMD_FREE,  14'd0,     12'd2);
      send_request(CMD_ALLOC, 14'd4,     12'd0);      // matches the altered length
      send_request(CMD_FREE,  14'd0,     12'd12);     // bad: equals bump pointer
      send_request(CMD_FREE,  14'd0,     12'd11);
      send_request(CMD_FREE,  14'd0,     12'd10);
      send_request(CMD_ALLOC, 14'd12,    12'd0);
      send_request(CMD_ALLOC, 14'd16383, 12'd0);      // out of space
      send_request(CMD_ALLOC, 14'd8,     12'd2730);
      send_request(CMD_FREE,  14'd8191,  12'd14);
      send_request(CMD_FREE,  14'd8191,  12'd14);     // double free
      send_request(CMD_ALLOC, 14'd8,     12'd1365);

      write_arena_limit(13'd600);
      random_requests(350);
      write_arena_limit(13'd2);                       // smallest limit: reuse only
      random_requests(250);
      write_arena_limit(13'd8191);                    // above the arena size
      random_requests(450);
      write_arena_limit(13'd4096);
      random_requests(300);
      write_arena_limit(LIMIT_W'($urandom_range(2, 4096)));
      idle_enable = 1'b0;
      random_requests(350);
      wait_idle();

      $display("%0d requests, %0d responses: %0d ok, %0d out of space, %0d bad free",
               sent_count, heap_model.checked, heap_model.status_count[STATUS_OK],
               heap_model.status_count[STATUS_NO_SPACE],
               heap_model.status_count[STATUS_BAD_FREE]);
      $display("%0d exact-fit reuses; bump pointer ended at %0d; last arena limit %0d",
               heap_model.reuse_count, heap_model.bump_ptr, last_limit);
      if (heap_model.errors == 0 && heap_model.result_q.size() == 0) begin
         $display("[exact_fit_heap_allocator_top] OK");
      end else begin
         $display("[exact_fit_heap_allocator_top] ERROR");
      end
      $finish;
   end

endmodule

FILE: exact_fit_heap_allocator_top.f
hdl/efha_pkg.sv
hdl/efha_ctrl.sv
hdl/efha_datapath.sv
hdl/exact_fit_heap_allocator_top.sv
verif/exact_fit_heap_allocator_top_tb.sv
